### hdl/whc_pkg.sv
package whc_pkg;

    // Largest accepted image dimension.
    localparam int DIM_LIMIT = 65535;

    // The accumulator only ever holds values up to DIM_LIMIT.
    localparam int ACC_W  = $clog2(DIM_LIMIT + 1);
    // One more 7-bit group shifted in.
    localparam int WIDE_W = ACC_W + 7;

    localparam logic [7:0] FIXED_MASK = 8'h9F;

    // Depth of the verdict queue between front and back.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [2:0] RS_OK     = 3'd0;
    localparam logic [2:0] RS_TYPE   = 3'd1;
    localparam logic [2:0] RS_FIXED  = 3'd2;
    localparam logic [2:0] RS_WIDTH  = 3'd3;
    localparam logic [2:0] RS_HEIGHT = 3'd4;
    localparam logic [2:0] RS_TRUNC  = 3'd5;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] reason;
    } verdict_t;

    // Transaction from the front parser into the queue.
    typedef struct packed {
        logic     push;
        verdict_t verdict;
    } verdict_push_t;

endpackage

### hdl/whc_front.sv
module whc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  whc_pkg::byte_item_t    byte_item,
    input  logic                   queue_full,
    output whc_pkg::verdict_push_t vpush
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_FIXED,
        PH_WIDTH,
        PH_HEIGHT
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [whc_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                       done_reg, done_next;

    logic [whc_pkg::WIDE_W-1:0] wide;
    logic                       over;
    logic                       accept;
    logic                       have;
    logic [2:0]                 reason;
    logic [2:0]                 dim_bad;

    // Each byte causes at most one verdict, so one free queue slot is enough.
    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    assign wide    = {acc_reg, byte_item.byte_value[6:0]};
    assign over    = wide > whc_pkg::WIDE_W'(whc_pkg::DIM_LIMIT);
    assign dim_bad = (phase_reg == PH_WIDTH) ? whc_pkg::RS_WIDTH : whc_pkg::RS_HEIGHT;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        done_next  = done_reg;
        have       = 1'b0;
        reason     = whc_pkg::RS_OK;
        if (accept)
        begin
            if (!done_reg)
            begin
                case (phase_reg)
                    PH_TYPE:
                    begin
                        if (byte_item.byte_value != 8'd0)
                        begin
                            have   = 1'b1;
                            reason = whc_pkg::RS_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_FIXED;
                        end
                    end
                    PH_FIXED:
                    begin
                        if ((byte_item.byte_value & whc_pkg::FIXED_MASK) != 8'd0)
                        begin
                            have   = 1'b1;
                            reason = whc_pkg::RS_FIXED;
                        end
                        else
                        begin
                            phase_next = PH_WIDTH;
                            acc_next   = '0;
                        end
                    end
                    PH_WIDTH, PH_HEIGHT:
                    begin
                        // Reject as soon as the running value passes the limit.
                        if (over)
                        begin
                            have   = 1'b1;
                            reason = dim_bad;
                        end
                        else if (byte_item.byte_value[7])
                        begin
                            acc_next = wide[whc_pkg::ACC_W-1:0];
                        end
                        else if (wide == '0)
                        begin
                            have   = 1'b1;
                            reason = dim_bad;
                        end
                        else if (phase_reg == PH_WIDTH)
                        begin
                            phase_next = PH_HEIGHT;
                            acc_next   = '0;
                        end
                        else
                        begin
                            have   = 1'b1;
                            reason = whc_pkg::RS_OK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TYPE;
                    end
                endcase
                if (!have && byte_item.last_byte)
                begin
                    have   = 1'b1;
                    reason = whc_pkg::RS_TRUNC;
                end
                if (have)
                begin
                    done_next = 1'b1;
                end
            end
            if (byte_item.last_byte)
            begin
                phase_next = PH_TYPE;
                acc_next   = '0;
                done_next  = 1'b0;
            end
        end
    end

    assign vpush.push             = have;
    assign vpush.verdict.accepted = (reason == whc_pkg::RS_OK);
    assign vpush.verdict.reason   = reason;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

endmodule

### hdl/whc_queue.sv
module whc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  whc_pkg::verdict_push_t vpush,
    output logic                   full,
    output logic                   q_valid,
    output whc_pkg::verdict_t      q_item,
    input  logic                   pop
);

    whc_pkg::verdict_t          mem [whc_pkg::QDEPTH];
    logic [whc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [whc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [whc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_pop;

    function automatic logic [whc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [whc_pkg::QPTR_W-1:0] p
    );
        if (p == whc_pkg::QPTR_W'(whc_pkg::QDEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full    = (count_reg == whc_pkg::QCNT_W'(whc_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = vpush.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (vpush.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!vpush.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vpush.push)
        begin
            mem[wr_ptr_reg] <= vpush.verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/whc_back.sv
module whc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  whc_pkg::verdict_t q_item,
    output logic              pop,
    output logic              verdict_valid,
    input  logic              verdict_ready,
    output whc_pkg::verdict_t verdict_item
);

    logic              out_valid_reg, out_valid_next;
    whc_pkg::verdict_t out_item_reg;

    // Refill the output register whenever it is empty or being drained.
    assign pop = q_valid && (!out_valid_reg || verdict_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict_item  = out_item_reg;

endmodule

### hdl/wbmp_header_checker_unit.sv
// Accepts one buffer byte per cycle unless stalled; the parser needs a single shift-or and
// compare per byte. The verdict of the deciding byte is written into the verdict queue and
// then loaded into the output register, which raises verdict_valid.
// The parser stalls only when the two-entry verdict queue is full, which happens
// only while the consumer holds off the output register.
// Reset is asynchronous and active low; it clears the parse phase, the accumulator,
// the queue and the output valid flag. No clearing pass follows reset.
module wbmp_header_checker_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  whc_pkg::byte_item_t byte_item,
    output logic                verdict_valid,
    input  logic                verdict_ready,
    output whc_pkg::verdict_t   verdict_item
);

    whc_pkg::verdict_push_t vpush;
    logic                   queue_full;
    logic                   q_valid;
    whc_pkg::verdict_t      q_item;
    logic                   pop;

    whc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .queue_full (queue_full),
        .vpush      (vpush)
    );

    whc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .vpush   (vpush),
        .full    (queue_full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop)
    );

    whc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_item  (verdict_item)
    );

endmodule

### bench/whc_verdict_checker.sv
module whc_verdict_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_ready,
    input  whc_pkg::byte_item_t byte_item,
    input  logic                verdict_valid,
    input  logic                verdict_ready,
    input  whc_pkg::verdict_t   verdict_item,
    output int                  error_count,
    output int                  pending,
    output int                  verdict_count,
    output int                  accept_count
);

    typedef enum logic [1:0] {
        EXPECT_TYPE,
        EXPECT_FIXED,
        READ_WIDTH,
        READ_HEIGHT
    } hdr_phase_t;

    typedef enum logic [1:0] {
        DIM_MORE,
        DIM_DONE,
        DIM_BAD
    } dim_result_t;

    whc_pkg::verdict_t expected_verdicts[$];
    hdr_phase_t        hdr_phase;
    logic [31:0]       dim_acc;
    logic              verdict_done;
    whc_pkg::verdict_t predicted;
    whc_pkg::verdict_t want;

    // Shifts one 7-bit group into the dimension being read.
    function automatic dim_result_t feed_dimension(input logic [7:0] b);
        dim_acc = (dim_acc << 7) | {25'd0, b[6:0]};
        if (dim_acc > whc_pkg::DIM_LIMIT)
            return DIM_BAD;
        if (b[7])
            return DIM_MORE;
        return (dim_acc == 0) ? DIM_BAD : DIM_DONE;
    endfunction

    // Advances the header parse by one byte; returns 1 when the byte yields a verdict.
    function automatic logic predict_verdict(input logic [7:0] b, input logic last,
                                             output whc_pkg::verdict_t v);
        logic        have;
        logic [2:0]  why;
        dim_result_t r;
        have = 1'b0;
        why  = whc_pkg::RS_OK;
        if (!verdict_done)
        begin
            case (hdr_phase)
                EXPECT_TYPE:
                begin
                    if (b != 8'd0)
                    begin
                        have = 1'b1;
                        why  = whc_pkg::RS_TYPE;
                    end
                    else
                        hdr_phase = EXPECT_FIXED;
                end
                EXPECT_FIXED:
                begin
                    if ((b & whc_pkg::FIXED_MASK) != 8'd0)
                    begin
                        have = 1'b1;
                        why  = whc_pkg::RS_FIXED;
                    end
                    else
                    begin
                        hdr_phase = READ_WIDTH;
                        dim_acc   = '0;
                    end
                end
                READ_WIDTH:
                begin
                    r = feed_dimension(b);
                    if (r == DIM_BAD)
                    begin
                        have = 1'b1;
                        why  = whc_pkg::RS_WIDTH;
                    end
                    else if (r == DIM_DONE)
                    begin
                        hdr_phase = READ_HEIGHT;
                        dim_acc   = '0;
                    end
                end
                default:
                begin
                    r = feed_dimension(b);
                    if (r == DIM_BAD)
                    begin
                        have = 1'b1;
                        why  = whc_pkg::RS_HEIGHT;
                    end
                    else if (r == DIM_DONE)
                    begin
                        have = 1'b1;
                        why  = whc_pkg::RS_OK;
                    end
                end
            endcase
            if (!have && last)
            begin
                have = 1'b1;
                why  = whc_pkg::RS_TRUNC;
            end
            if (have)
                verdict_done = 1'b1;
        end
        // The last byte always starts a fresh buffer.
        if (last)
        begin
            hdr_phase    = EXPECT_TYPE;
            dim_acc      = '0;
            verdict_done = 1'b0;
        end
        v.accepted = (why == whc_pkg::RS_OK);
        v.reason   = why;
        return have;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_verdicts.delete();
            hdr_phase     = EXPECT_TYPE;
            dim_acc       = '0;
            verdict_done  = 1'b0;
            error_count   = 0;
            pending       = 0;
            verdict_count = 0;
            accept_count  = 0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                if (predict_verdict(byte_item.byte_value, byte_item.last_byte, predicted))
                    expected_verdicts.push_back(predicted);
            end
            if (verdict_valid && verdict_ready)
            begin
                verdict_count++;
                if (verdict_item.accepted)
                    accept_count++;
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict: expected none, got accepted=%0b reason=%0d",
                             $time, verdict_item.accepted, verdict_item.reason);
                    error_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict_item.accepted !== want.accepted)
                    begin
                        $display("%0t: accepted mismatch: expected %0b, got %0b",
                                 $time, want.accepted, verdict_item.accepted);
                        error_count++;
                    end
                    if (verdict_item.reason !== want.reason)
                    begin
                        $display("%0t: reason mismatch: expected %0d, got %0d",
                                 $time, want.reason, verdict_item.reason);
                        error_count++;
                    end
                end
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

### bench/tb.sv
module tb;

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_BYTES  = 700;
    localparam int HOLD_CYCLES   = 60;
    localparam int BURST_BUFFERS = 6;
    localparam int DRAIN_CYCLES  = 10;

    logic                clk;
    logic                rst_n;
    logic                byte_valid;
    logic                byte_ready;
    whc_pkg::byte_item_t byte_item;
    logic                verdict_valid;
    logic                verdict_ready;
    whc_pkg::verdict_t   verdict_item;

    int mismatch_count;
    int verdicts_waiting;
    int verdicts_seen;
    int headers_accepted;

    int         bytes_sent;
    int         buffers_sent;
    int         random_end;
    logic       quiet;
    logic       hold_off_req;
    logic       burst_done;
    logic [7:0] hdr_buf[$];

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    wbmp_header_checker_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_item     (byte_item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_item  (verdict_item)
    );

    whc_verdict_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_item     (byte_item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_item  (verdict_item),
        .error_count   (mismatch_count),
        .pending       (verdicts_waiting),
        .verdict_count (verdicts_seen),
        .accept_count  (headers_accepted)
    );

    // Sends one byte; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!quiet && $urandom_range(99) < 14)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{byte_value: b, last_byte: last};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < hdr_buf.size(); i++)
            send_byte(hdr_buf[i], i == hdr_buf.size() - 1);
        buffers_sent++;
    endtask

    // Lets every expected verdict come out, then idles with byte_valid low.
    task automatic drain();
        byte_valid <= 1'b0;
        wait (verdicts_waiting == 0);
        @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Appends a dimension as 7-bit groups, most significant first.
    function automatic void append_dim(input int unsigned value, input int lead);
        int groups;
        groups = 1;
        while (groups < 5 && (value >> (7 * groups)) != 0)
            groups++;
        repeat (lead) hdr_buf.push_back(8'h80);
        for (int i = groups - 1; i >= 0; i--)
            hdr_buf.push_back({i != 0, 7'(value >> (7 * i))});
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(9))
            0:       return 1;
            1:       return whc_pkg::DIM_LIMIT;
            2:       return whc_pkg::DIM_LIMIT + 1 + $urandom_range(2097152);
            3:       return 0;
            4:       return $urandom_range(1, 127);
            default: return $urandom_range(1, whc_pkg::DIM_LIMIT);
        endcase
    endfunction

    function automatic int pick_lead();
        return ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    function automatic void append_noise(input int count);
        repeat (count) hdr_buf.push_back(8'($urandom));
    endfunction

    function automatic void build_header();
        hdr_buf.push_back(8'h00);
        if ($urandom_range(7) == 0)
            hdr_buf.push_back(8'($urandom) & ~whc_pkg::FIXED_MASK);
        else
            hdr_buf.push_back({1'b0, 2'($urandom), 5'd0});
        append_dim(pick_dim(), pick_lead());
        append_dim(pick_dim(), pick_lead());
    endfunction

    // Mostly well-formed headers with random content, the rest broken or noise.
    function automatic void build_random_buffer();
        int kind;
        int cut;
        hdr_buf.delete();
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            build_header();
            append_noise($urandom_range(3));
        end
        else if (kind < 70)
        begin
            build_header();
            cut = $urandom_range(1, hdr_buf.size() - 1);
            while (hdr_buf.size() > cut)
                void'(hdr_buf.pop_back());
        end
        else if (kind < 80)
        begin
            hdr_buf.push_back(8'($urandom_range(1, 255)));
            append_noise($urandom_range(4));
        end
        else if (kind < 90)
        begin
            hdr_buf.push_back(8'h00);
            hdr_buf.push_back(8'($urandom) | (8'h01 << $urandom_range(4)));
            append_noise($urandom_range(4));
        end
        else
            append_noise($urandom_range(1, 12));
    endfunction

    // Receiver: random back-pressure, or one long hold-off when asked.
    initial
    begin
        verdict_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req  <= 1'b0;
                verdict_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                verdict_ready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    initial
    begin
        #2000000;
        $display("Run timed out with %0d verdicts still expected.", verdicts_waiting);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        byte_item    = '0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        burst_done   = 1'b0;
        bytes_sent   = 0;
        buffers_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed buffers: a lone type byte, a bad type, a bad fixed byte on the last
        // byte, the smallest dimensions, the largest width with an oversized height
        // followed by an ignored byte, a zero width after a leading zero group, and a
        // buffer that ends inside the width.
        hdr_buf = '{8'h00};
        send_buffer();
        hdr_buf = '{8'hFF};
        send_buffer();
        hdr_buf = '{8'h00, 8'h9F};
        send_buffer();
        hdr_buf = '{8'h00, 8'h60, 8'h01, 8'h01};
        send_buffer();
        hdr_buf = '{8'h00, 8'h00, 8'h83, 8'hFF, 8'h7F, 8'h84, 8'h80, 8'h00, 8'h00};
        send_buffer();
        hdr_buf = '{8'h00, 8'h00, 8'h80, 8'h00};
        send_buffer();
        hdr_buf = '{8'h00, 8'h00, 8'h81};
        send_buffer();

        // The sender waits here until every verdict so far has come out.
        drain();

        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end)
        begin
            if (!burst_done && bytes_sent >= random_end - RANDOM_BYTES / 3)
            begin
                // Output held off while short headers keep coming, so the
                // verdict queue fills and the input stalls.
                burst_done   = 1'b1;
                quiet        <= 1'b1;
                hold_off_req <= 1'b1;
                for (int n = 0; n < BURST_BUFFERS; n++)
                begin
                    hdr_buf = '{8'h00, 8'h00, 8'h01, 8'h01};
                    send_buffer();
                end
            end
            quiet <= (bytes_sent >= random_end - RANDOM_BYTES + 250) &&
                     (bytes_sent <  random_end - RANDOM_BYTES + 370);
            build_random_buffer();
            send_buffer();
        end
        quiet <= 1'b0;
        drain();

        $display("Sent %0d bytes in %0d buffers; checked %0d verdicts, %0d of them accepting.",
                 bytes_sent, buffers_sent, verdicts_seen, headers_accepted);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/whc_pkg.sv
hdl/whc_front.sv
hdl/whc_queue.sv
hdl/whc_back.sv
hdl/wbmp_header_checker_unit.sv
bench/whc_verdict_checker.sv
bench/tb.sv
